// File: hw/rtl/sgcm_pkg.sv
// ----------------------------------------------------------------------------
// Sobel gradient colour map package
// Shared widths, register indexes, controller states and helpers.
// ----------------------------------------------------------------------------
package sgcm_pkg;

  localparam int PixW          = 8;
  localparam int WidthRegW     = 11;
  localparam int HeightRegW    = 13;
  localparam int RowW          = HeightRegW + 1;
  localparam int CfgIdxW       = 8;
  localparam int CfgDataW      = 13;
  localparam int MaxWidthDflt  = 1024;
  localparam int WidthReset    = 1024;
  localparam int HeightReset   = 1024;

  // grey = floor(sum * GreyRecip / 2^GreyShift), exact for sums up to 2550
  localparam int GreySumW      = 12;
  localparam int GreyRecip     = 6554;
  localparam int GreyShift     = 16;
  localparam int GreyProdW     = 25;

  localparam int GradW         = 12;
  localparam int SqrtW         = 24;
  localparam int RootW         = 12;
  localparam int ColourW       = 14;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SQUARE,
    S_ROOT,
    S_DONE
  } state_e;

  function automatic logic [PixW-1:0] clamp_pix(input logic signed [ColourW-1:0] v);
    logic [PixW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ColourW'(255)) begin
      r = '1;
    end else begin
      r = v[PixW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/sobel_gradient_colour_map.sv
// ----------------------------------------------------------------------------
// Sobel gradient colour map
// Streams RGB pixels in raster order, converts them to grey, forms a 3x3
// zero-padded window from two line stores and emits a gradient colour.
// ----------------------------------------------------------------------------
// A frame is image_width*image_height pixels followed by image_width+1 flush
// beats; the result for a pixel leaves once the pixel one row and one column
// beyond it has arrived, and the final result carries tlast. An input beat
// that yields no result occupies the block through a line store read, then
// write back; a beat that yields a result occupies it also through squaring,
// the two-bits-per-step square root unit and a wait while the output register
// stays full. One finished result waits in the output register while the next
// beat is taken. A configuration write restarts the frame; widths saturate to
// 1..MAX_WIDTH and a height of zero counts as one.
module sobel_gradient_colour_map #(
  parameter int MAX_WIDTH = sgcm_pkg::MaxWidthDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [23:0]                  s_axis_tdata_i,   // red, green, blue
  input  logic                         s_axis_tuser_i,   // flush
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [23:0]                  m_axis_tdata_o,   // out_red, out_green, out_blue
  output logic                         m_axis_tlast_o,   // frame_last
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sgcm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sgcm_pkg::CfgDataW-1:0] cfg_data_i
);
  import sgcm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  state_e state_q, state_d;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [CW-1:0]         col_q;
  logic [RowW-1:0]       row_q;
  logic [PixW-1:0]       win_q [3][3];

  logic [PixW-1:0] upper_mem [MAX_WIDTH];
  logic [PixW-1:0] middle_mem [MAX_WIDTH];
  logic [PixW-1:0] rd_upper_q, rd_mid_q;
  logic [PixW-1:0] grey_q;

  logic signed [GradW-1:0] gx_q, gy_q;
  logic                    last_q;
  logic [SqrtW-1:0]        root_v_q, root_res_q, root_bit_q;
  logic [SqrtW-1:0]        root_v_d, root_res_d, root_trial;

  logic            out_valid_q;
  logic [23:0]     out_data_q;
  logic            out_last_q;

  logic in_fire, cfg_fire, load_out;
  logic [CW-1:0]         w_eff, col_inc;
  logic [HeightRegW-1:0] h_eff;
  logic [RowW-1:0]       h_plus;
  logic                  row_past;
  logic [GreySumW-1:0]   grey_sum;
  logic [GreyProdW-1:0]  grey_prod;
  logic [PixW-1:0]       grey_new;
  logic [PixW-1:0]       top, mid;
  logic [PixW-1:0]       col_l [3];
  logic [PixW-1:0]       col_c [3];
  logic [PixW-1:0]       col_r [3];
  logic signed [GradW-1:0] gx_c, gy_c;
  logic emit_c, last_c, wrap_c;
  logic [RowW-1:0] row_next;
  logic [CW-1:0]   col_next;
  logic [2*GradW-1:0] sq_x, sq_y;
  logic signed [ColourW-1:0] m_s, red_s, green_s, blue_s;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // effective frame size
  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    h_eff    = (height_q == '0) ? HeightRegW'(1) : height_q;
    h_plus   = {1'b0, h_eff} + RowW'(1);
    row_past = row_q >= {1'b0, h_eff};
  end

  // grey conversion
  always_comb begin
    grey_sum  = GreySumW'(3) * GreySumW'(s_axis_tdata_i[7:0])
              + GreySumW'(6) * GreySumW'(s_axis_tdata_i[15:8])
              + GreySumW'(s_axis_tdata_i[23:16]);
    grey_prod = GreyProdW'(grey_sum) * GreyProdW'(GreyRecip);
    grey_new  = (s_axis_tuser_i || row_past) ? '0
              : grey_prod[GreyShift +: PixW];
  end

  // window update and gradients
  always_comb begin
    top = (row_q >= RowW'(2)) ? rd_upper_q : '0;
    mid = (row_q != '0) ? rd_mid_q : '0;
    for (int k = 0; k < 3; k++) begin
      col_l[k] = win_q[k][1];
      col_c[k] = win_q[k][2];
    end
    col_r[0] = (col_q == '0) ? '0 : top;
    col_r[1] = (col_q == '0) ? '0 : mid;
    col_r[2] = (col_q == '0) ? '0 : grey_q;
    gx_c = (GradW'(col_l[0]) + (GradW'(col_l[1]) << 1) + GradW'(col_l[2]))
         - (GradW'(col_r[0]) + (GradW'(col_r[1]) << 1) + GradW'(col_r[2]));
    gy_c = (GradW'(col_l[0]) + (GradW'(col_c[0]) << 1) + GradW'(col_r[0]))
         - (GradW'(col_l[2]) + (GradW'(col_c[2]) << 1) + GradW'(col_r[2]));
    emit_c = (col_q == '0) ? (row_q >= RowW'(2)) : (row_q != '0);
    last_c = (col_q == '0) && (row_q == h_plus);
    wrap_c = (col_q == '0) && (row_q >= h_plus);
    col_inc = col_q + CW'(1);
    if (wrap_c) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = row_q + RowW'(1);
    end else begin
      col_next = col_inc;
      row_next = row_q;
    end
  end

  // square root step
  always_comb begin
    root_trial = root_res_q + root_bit_q;
    if (root_v_q >= root_trial) begin
      root_v_d   = root_v_q - root_trial;
      root_res_d = (root_res_q >> 1) + root_bit_q;
    end else begin
      root_v_d   = root_v_q;
      root_res_d = root_res_q >> 1;
    end
    sq_x = (2*GradW)'(gx_q) * (2*GradW)'(gx_q);
    sq_y = (2*GradW)'(gy_q) * (2*GradW)'(gy_q);
  end

  // colour mapping
  always_comb begin
    m_s     = $signed({2'b00, root_res_q[RootW-1:0]});
    red_s   = (ColourW'(gy_q) <<< 1) + m_s;
    green_s = (ColourW'(gx_q) <<< 1) + m_s;
    blue_s  = -((ColourW'(gx_q) + ColourW'(gy_q)) <<< 1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire) state_d = S_READ;
      S_READ:   state_d = emit_c ? S_SQUARE : S_IDLE;
      S_SQUARE: state_d = S_ROOT;
      S_ROOT:   if (root_bit_q[0]) state_d = S_DONE;
      S_DONE:   if (!out_valid_q || m_axis_tready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    cfg_ready_o     = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cfg_ready_o     = 1'b1;
        s_axis_tready_o = !cfg_valid_i;
      end
      S_DONE:   load_out = !out_valid_q || m_axis_tready_i;
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= WidthRegW'(WidthReset);
      height_q    <= HeightRegW'(HeightReset);
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        if (cfg_index_i == CfgImageWidth) begin
          width_q <= cfg_data_i[WidthRegW-1:0];
        end
        if (cfg_index_i == CfgImageHeight) begin
          height_q <= cfg_data_i[HeightRegW-1:0];
        end
        if (cfg_index_i == CfgImageWidth || cfg_index_i == CfgImageHeight) begin
          col_q <= '0;
          row_q <= '0;
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              win_q[i][j] <= '0;
            end
          end
        end
      end else if (state_q == S_READ) begin
        col_q <= col_next;
        row_q <= row_next;
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= (col_q == '0) ? '0 : win_q[k][1];
          win_q[k][1] <= (col_q == '0) ? '0 : win_q[k][2];
        end
        win_q[0][2] <= top;
        win_q[1][2] <= mid;
        win_q[2][2] <= grey_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line stores: read on accept, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_upper_q <= upper_mem[col_q[AW-1:0]];
      rd_mid_q   <= middle_mem[col_q[AW-1:0]];
    end
    if (state_q == S_READ) begin
      upper_mem[col_q[AW-1:0]]  <= rd_mid_q;
      middle_mem[col_q[AW-1:0]] <= grey_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      grey_q <= grey_new;
    end
    if (state_q == S_READ) begin
      gx_q   <= gx_c;
      gy_q   <= gy_c;
      last_q <= last_c;
    end
    if (state_q == S_SQUARE) begin
      root_v_q   <= SqrtW'(sq_x + sq_y) << 2;
      root_res_q <= '0;
      root_bit_q <= SqrtW'(1) << (SqrtW - 2);
    end else if (state_q == S_ROOT) begin
      root_v_q   <= root_v_d;
      root_res_q <= root_res_d;
      root_bit_q <= root_bit_q >> 2;
    end
    if (load_out) begin
      out_data_q <= {clamp_pix(blue_s), clamp_pix(green_s), clamp_pix(red_s)};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_READ)
    else $error("accepted beat did not start a line store access");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < w_eff)
    else $error("column position beyond frame width");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && last_c && !cfg_fire) |=> (col_q == '0 && row_q == '0))
    else $error("frame end did not return position to start");

  a_root_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> root_res_q < SqrtW'(4096))
    else $error("square root result out of range");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel gradient colour map testbench
// Feeds RGB frames in raster order, each followed by its flush beats unless
// cut short, and predicts each gradient colour from a model of the grey line
// stores and the 3x3 window or from the directed table. Output beats are
// checked field by field in order. Both stream sides idle at random. The run
// covers a partial frame at the reset size, a directed table, the first beats
// of frames at the extreme sizes and random frames.
// ----------------------------------------------------------------------------
module testbench;
  import sgcm_pkg::*;

  localparam int MaxWidth     = MaxWidthDflt;
  localparam int SettleCycles = 32;
  localparam int CycleLimit   = 2_000_000;
  localparam int ExtremeBeats = 16;
  localparam int RandomBeats  = 100;
  localparam logic [CfgIdxW-1:0] CfgNoReg = '1;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;

  typedef struct packed {
    logic       flush;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  // top in [0], middle in [1], bottom in [2]
  typedef logic [2:0][7:0] column_t;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic                flush;
    logic                typed;
    logic [7:0]          out_red;
    logic [7:0]          out_green;
    logic [7:0]          out_blue;
    logic                out_last;
  } stim_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [23:0]         s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [23:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  stim_row_t directed_rows [27] = '{
    '{ROW_CFG,  CfgImageWidth,  13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG,  CfgImageHeight, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
    '{ROW_CFG,  CfgImageWidth,  13'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG,  CfgImageHeight, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 8'd0, 8'd255, 8'd255, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 8'd255, 8'd255, 8'd0, 1'b1},
    '{ROW_CFG,  CfgImageWidth,  13'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG,  CfgImageHeight, 13'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd128, 8'd64, 8'd32, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd37, 8'd200, 8'd90, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_BEAT, 8'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
    '{ROW_CFG,  CfgNoReg, 13'h1FFF, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0}
  };

  logic [7:0]           grey_upper [MaxWidth];
  logic [7:0]           grey_middle [MaxWidth];
  column_t              win [3];
  int                   col_pos;
  int                   row_pos;
  logic [WidthRegW-1:0] width_reg;
  logic [HeightRegW-1:0] height_reg;

  colour_t colours_due[$];
  int      errors      = 0;
  int      beats_sent  = 0;
  int      cycle_count = 0;
  int      send_left   = 0;
  bit      send_quiet  = 1'b0;
  int      recv_left   = 0;
  bit      recv_quiet  = 1'b0;

  sobel_gradient_colour_map i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int eff_width();
    if (width_reg == '0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  function automatic int isqrt(int v);
    int r;
    r = $rtoi($sqrt(real'(v)));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic colour_t shade(column_t l, column_t c, column_t r, logic last);
    int      gx;
    int      gy;
    int      m;
    colour_t res;
    gx = (int'(l[0]) + 2 * int'(l[1]) + int'(l[2])) - (int'(r[0]) + 2 * int'(r[1]) + int'(r[2]));
    gy = (int'(l[0]) + 2 * int'(c[0]) + int'(r[0])) - (int'(l[2]) + 2 * int'(c[2]) + int'(r[2]));
    m = isqrt(4 * (gx * gx + gy * gy));
    res.red   = clamp8(2 * gy + m);
    res.green = clamp8(2 * gx + m);
    res.blue  = clamp8(-2 * (gx + gy));
    res.last  = last;
    return res;
  endfunction

  function automatic int draw_wait(inout int left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(8, 64);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] draw_channel();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic grade(input pixel_t px, output bit got, output colour_t res);
    int         w;
    int         h;
    int         c;
    int         r;
    int         ci;
    logic [7:0] grey;
    logic [7:0] top;
    logic [7:0] mid;
    w    = eff_width();
    h    = eff_height();
    c    = col_pos;
    r    = row_pos;
    ci   = c % MaxWidth;
    grey = 8'd0;
    if (!px.flush && r < h) begin
      grey = 8'((3 * int'(px.red) + 6 * int'(px.green) + int'(px.blue)) / 10);
    end
    top = (r >= 2) ? grey_upper[ci] : 8'd0;
    mid = (r >= 1) ? grey_middle[ci] : 8'd0;
    grey_upper[ci]  = grey_middle[ci];
    grey_middle[ci] = grey;
    got = 1'b0;
    res = '0;
    if (c == 0) begin
      // close the previous row against right padding
      if (r >= 2) begin
        res = shade(win[1], win[2], '0, r == h + 1);
        got = 1'b1;
      end
      win[0] = '0;
      win[1] = '0;
    end else begin
      win[0] = win[1];
      win[1] = win[2];
    end
    win[2] = {grey, mid, top};
    if (c != 0 && r >= 1) begin
      res = shade(win[0], win[1], win[2], 1'b0);
      got = 1'b1;
    end
    if (c == 0 && r >= h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_axis_tvalid_i <= 1'b0;
    while (colours_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgImageWidth || idx == CfgImageHeight) begin
      if (idx == CfgImageWidth) begin
        width_reg = val[WidthRegW-1:0];
      end else begin
        height_reg = val[HeightRegW-1:0];
      end
      col_pos = 0;
      row_pos = 0;
      win     = '{default: '0};
    end
  endtask

  task automatic send_pixel(input pixel_t px, input bit typed, input colour_t want);
    int      gap;
    bit      got;
    colour_t res;
    gap = draw_wait(send_left, send_quiet);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {px.blue, px.green, px.red};
    s_axis_tuser_i  <= px.flush;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_sent++;
    grade(px, got, res);
    if (typed) begin
      colours_due.push_back(want);
    end else if (got) begin
      colours_due.push_back(res);
    end
  endtask

  // send the frame at the current size, cut short after limit beats
  task automatic send_frame(input int limit);
    int     w;
    int     pixels;
    int     total;
    pixel_t px;
    w      = eff_width();
    pixels = w * eff_height();
    total  = pixels + w + 1;
    if (limit < total) total = limit;
    for (int i = 0; i < total; i++) begin
      px.red   = draw_channel();
      px.green = draw_channel();
      px.blue  = draw_channel();
      px.flush = (i < pixels) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 3) != 0);
      send_pixel(px, 1'b0, '0);
    end
  endtask

  initial begin
    int      stall;
    colour_t seen;
    colour_t due;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(recv_left, recv_quiet);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      seen = {m_axis_tlast_o, m_axis_tdata_o};
      if (colours_due.size() == 0) begin
        $error("colour beat with none due: %h", seen);
        errors++;
      end else begin
        due = colours_due.pop_front();
        if (seen.red !== due.red) begin
          $error("out_red expected %0d got %0d", due.red, seen.red);
          errors++;
        end
        if (seen.green !== due.green) begin
          $error("out_green expected %0d got %0d", due.green, seen.green);
          errors++;
        end
        if (seen.blue !== due.blue) begin
          $error("out_blue expected %0d got %0d", due.blue, seen.blue);
          errors++;
        end
        if (seen.last !== due.last) begin
          $error("frame_last expected %0d got %0d", due.last, seen.last);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t entry;
    int        w;
    int        h;
    int        total;
    int        start;
    int        remain;
    int        cut;
    for (int i = 0; i < MaxWidth; i++) begin
      grey_upper[i]  = 8'd0;
      grey_middle[i] = 8'd0;
    end
    win        = '{default: '0};
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = WidthRegW'(WidthReset);
    height_reg = HeightRegW'(HeightReset);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // partial frame at the reset size: one row plus three beats
    send_frame(eff_width() + 3);

    foreach (directed_rows[i]) begin
      entry = directed_rows[i];
      if (entry.kind == ROW_CFG) begin
        write_reg(entry.index, entry.value);
      end else begin
        send_pixel({entry.flush, entry.blue, entry.green, entry.red}, entry.typed,
                   {entry.out_last, entry.out_blue, entry.out_green, entry.out_red});
      end
    end

    write_reg(CfgImageWidth, CfgDataW'(1));
    write_reg(CfgImageHeight, CfgDataW'(4096));
    send_frame(ExtremeBeats);
    write_reg(CfgImageWidth, '1);
    write_reg(CfgImageHeight, CfgDataW'(1));
    send_frame(ExtremeBeats);

    start = beats_sent;
    while (beats_sent - start < RandomBeats) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      h = $urandom_range(1, 10);
      write_reg(CfgImageWidth, CfgDataW'(w));
      write_reg(CfgImageHeight, CfgDataW'(h));
      total = w * h + w + 1;
      // drop out of some frames early
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
      remain = RandomBeats - (beats_sent - start);
      if (cut > remain) cut = remain;
      send_frame(cut);
    end

    s_axis_tvalid_i <= 1'b0;
    while (colours_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
